/* rtl/u8sd_pkg.sv */
// Shared types, constants and a helper function for the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int CP_W  = 31;
  localparam int CNT_W = 3;
  localparam int LO_W  = 4;

  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD_MASK  = 8'h7f;

  typedef struct packed {
    logic [CNT_W-1:0] held_count;
    logic [CNT_W-1:0] bytes_expected;
    logic [CP_W-1:0]  partial_value;
  } frame_t;

  typedef struct packed {
    logic [CNT_W-1:0] err_cnt;
    logic             fin_vld;
    logic             fin_valid;
    logic [CNT_W-1:0] fin_count;
    logic [CP_W-1:0]  fin_code;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] sel;
    logic [7:0]       data;
  } hold_wr_t;

  // Count of leading one bits, scanning from the top bit.
  function automatic logic [LO_W-1:0] lead_ones(input logic [7:0] b);
    logic [LO_W-1:0] n;
    logic            run;
    n   = '0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + LO_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

/* rtl/utf8_stream_decoder_top.sv */
// Top level of the UTF-8 stream decoder with its frame state and result queue.
//
// Channel | Signals                                         | Direction
// input   | in_valid, in_stall, byte_in, end_of_text        | into block
// output  | out_valid, out_stall, code_point, valid_res,    | out of block
//         | byte_count, last_of_run                         |
//
// Each item is decoded in the cycle it is accepted and its results are
// registered, so an item giving at most one result passes at one per cycle when out_stall is low.
// An item that breaks a frame of k held bytes gives k error results, plus one
// more when the breaking byte yields a result of its own, one per cycle unless
// out_stall holds them; the input stalls until the last of them is being taken.
// Reset closes any open frame and drops pending results.
module utf8_stream_decoder_top import u8sd_pkg::*; #(
  parameter int MAX_SEQUENCE_BYTES = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      byte_in,
  input  logic            end_of_text,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] code_point,
  output logic            valid_res,
  output logic [CNT_W-1:0] byte_count,
  output logic            last_of_run
);

  localparam int HOLD_D = MAX_SEQUENCE_BYTES - 1;

  frame_t     st;
  frame_t     st_next;
  job_t       job;
  job_t       job_next;
  hold_wr_t   hold_wr;
  logic [7:0] held [HOLD_D];
  logic [7:0] jb   [HOLD_D];
  logic       acc_in;
  logic       pop;
  logic       last;

  u8sd_decode #(
    .MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)
  ) u_decode (
    .st         (st),
    .byte_in    (byte_in),
    .end_of_text(end_of_text),
    .st_next    (st_next),
    .job_next   (job_next),
    .hold_wr    (hold_wr)
  );

  assign out_valid = (job.err_cnt != '0) || job.fin_vld;
  assign last      = ((job.err_cnt == CNT_W'(1)) && !job.fin_vld) ||
                     ((job.err_cnt == '0) && job.fin_vld);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = out_valid && !(pop && last);
  assign acc_in    = in_valid && !in_stall;

  always_comb begin
    if (job.err_cnt != '0) begin
      code_point = {{(CP_W-8){1'b0}}, jb[0]};
      valid_res  = 1'b0;
      byte_count = CNT_W'(1);
    end else begin
      code_point = job.fin_code;
      valid_res  = job.fin_valid;
      byte_count = job.fin_count;
    end
    last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      job <= '0;
    end else if (acc_in) begin
      st  <= st_next;
      job <= job_next;
    end else if (pop) begin
      if (job.err_cnt != '0) begin
        job.err_cnt <= job.err_cnt - CNT_W'(1);
      end else begin
        job.fin_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HOLD_D; i++) begin
      if (acc_in && hold_wr.we && hold_wr.sel == CNT_W'(i)) begin
        held[i] <= hold_wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      for (int i = 0; i < HOLD_D; i++) begin
        jb[i] <= held[i];
      end
    end else if (pop && job.err_cnt != '0) begin
      for (int i = 0; i < HOLD_D - 1; i++) begin
        jb[i] <= jb[i+1];
      end
    end
  end

endmodule

/* rtl/u8sd_decode.sv */
// Combinational decode of one item against the open frame.
module u8sd_decode import u8sd_pkg::*; #(
  parameter int MAX_SEQUENCE_BYTES = 6
) (
  input  frame_t     st,
  input  logic [7:0] byte_in,
  input  logic       end_of_text,
  output frame_t     st_next,
  output job_t       job_next,
  output hold_wr_t   hold_wr
);

  logic [LO_W-1:0]  n;
  logic             fr_res;
  logic             fr_valid;
  logic [CP_W-1:0]  fr_code;
  logic [CP_W-1:0]  fr_part;
  logic             is_cont;
  logic [CP_W-1:0]  pv;
  logic [CNT_W:0]   cnt_inc;
  logic [7:0]       lead_bits;

  always_comb begin
    n         = lead_ones(byte_in);
    lead_bits = byte_in & (LEAD_MASK >> n);
    fr_part   = {{(CP_W-8){1'b0}}, lead_bits};
    fr_code   = {{(CP_W-8){1'b0}}, byte_in};
    fr_res    = 1'b0;
    fr_valid  = 1'b0;
    if (byte_in[7] == 1'b0) begin
      fr_res   = 1'b1;
      fr_valid = 1'b1;
    end else if (n < LO_W'(2) || n > LO_W'(MAX_SEQUENCE_BYTES)) begin
      fr_res   = 1'b1;
      fr_valid = 1'b0;
    end

    is_cont = (byte_in & CONT_MASK) == CONT_TAG;
    pv      = {st.partial_value[CP_W-7:0], byte_in[5:0]};
    cnt_inc = {1'b0, st.held_count} + (CNT_W+1)'(1);

    st_next      = st;
    job_next     = '0;
    hold_wr.we   = 1'b0;
    hold_wr.sel  = st.held_count;
    hold_wr.data = byte_in;

    if (end_of_text) begin
      job_next.err_cnt = st.held_count;
      st_next          = '0;
    end else if (st.held_count != '0 && is_cont) begin
      if (cnt_inc >= {1'b0, st.bytes_expected}) begin
        job_next.fin_vld   = 1'b1;
        job_next.fin_valid = 1'b1;
        job_next.fin_count = st.bytes_expected;
        job_next.fin_code  = pv;
        st_next            = '0;
      end else begin
        hold_wr.we            = 1'b1;
        st_next.held_count    = cnt_inc[CNT_W-1:0];
        st_next.partial_value = pv;
      end
    end else begin
      job_next.err_cnt = st.held_count;
      st_next          = '0;
      if (fr_res) begin
        job_next.fin_vld   = 1'b1;
        job_next.fin_valid = fr_valid;
        job_next.fin_count = CNT_W'(1);
        job_next.fin_code  = fr_code;
      end else begin
        hold_wr.we             = 1'b1;
        hold_wr.sel            = '0;
        st_next.held_count     = CNT_W'(1);
        st_next.bytes_expected = n[CNT_W-1:0];
        st_next.partial_value  = fr_part;
      end
    end
  end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the UTF-8 stream decoder, with its own decoder model.
`timescale 1ns / 100ps

module testbench import u8sd_pkg::*;;

  localparam int MAX_SEQ      = 6;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 16;

  typedef struct packed {
    logic [CP_W-1:0]  code;
    logic             ok;
    logic [CNT_W-1:0] count;
    logic             last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_item_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       byte_in = 8'h00;
  logic             end_of_text = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CP_W-1:0]  code_point;
  logic             valid_res;
  logic [CNT_W-1:0] byte_count;
  logic             last_of_run;

  utf8_stream_decoder_top #(.MAX_SEQUENCE_BYTES(MAX_SEQ)) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_in     (byte_in),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .valid_res   (valid_res),
    .byte_count  (byte_count),
    .last_of_run (last_of_run)
  );

  text_item_t      pending_bytes[$];
  decoded_t        expected_results[$];

  logic [7:0]      frame_bytes [0:MAX_SEQ-2];
  int unsigned     frame_held = 0;
  int unsigned     frame_len = 0;
  logic [CP_W-1:0] frame_value = '0;

  int   idle_pct = 0;
  int   stall_pct = 0;
  int   items_pushed = 0;
  int   items_taken = 0;
  int   outstanding = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   results_checked = 0;
  int   error_results = 0;
  int   hold_asked = 0;
  int   hold_seen = 0;
  int   hold_cnt = 0;
  logic in_took = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("tb: mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic int count_top_ones(input logic [7:0] b);
    int n;
    n = 0;
    while (n < 8 && b[7-n]) n++;
    return n;
  endfunction

  task automatic add_result(input logic [CP_W-1:0] code, input logic ok,
                            input logic [CNT_W-1:0] count);
    decoded_t r;
    r.code  = code;
    r.ok    = ok;
    r.count = count;
    r.last  = 1'b0;
    expected_results.push_back(r);
    if (!ok) error_results++;
  endtask

  task automatic flush_frame();
    for (int i = 0; i < frame_held; i++) add_result(CP_W'(frame_bytes[i]), 1'b0, CNT_W'(1));
    frame_held  = 0;
    frame_len   = 0;
    frame_value = '0;
  endtask

  task automatic open_or_emit(input logic [7:0] b);
    int n;
    if (b < 8'h80) begin
      add_result(CP_W'(b), 1'b1, CNT_W'(1));
    end else begin
      n = count_top_ones(b);
      if (n < 2 || n > MAX_SEQ) begin
        add_result(CP_W'(b), 1'b0, CNT_W'(1));
      end else begin
        frame_bytes[0] = b;
        frame_held     = 1;
        frame_len      = n;
        frame_value    = CP_W'(b & (8'h7f >> n));
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    int       before_n;
    decoded_t tail;
    before_n = expected_results.size();
    if (eot) begin
      flush_frame();
    end else if (frame_held > 0) begin
      if ((b & 8'hc0) == 8'h80) begin
        frame_value = {frame_value[CP_W-7:0], b[5:0]};
        if (frame_held + 1 >= frame_len) begin
          add_result(frame_value, 1'b1, CNT_W'(frame_len));
          frame_held  = 0;
          frame_len   = 0;
          frame_value = '0;
        end else begin
          frame_bytes[frame_held] = b;
          frame_held++;
        end
      end else begin
        flush_frame();
        open_or_emit(b);
      end
    end else begin
      open_or_emit(b);
    end
    if (expected_results.size() > before_n) begin
      tail = expected_results[expected_results.size()-1];
      tail.last = 1'b1;
      expected_results[expected_results.size()-1] = tail;
    end
  endtask

  always @(negedge clk) begin
    text_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_bytes.pop_front();
        byte_in     <= nxt.data;
        end_of_text <= nxt.eot;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
  end

  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_seen <= hold_asked;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    logic     took_in;
    logic     took_out;
    took_in  = in_valid && !in_stall;
    took_out = out_valid && !out_stall;
    if (rst) begin
      in_took      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (took_in) decode_byte(byte_in, end_of_text);
      if (took_out) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result code_point", 32'(code_point), 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (code_point !== want.code)
            report_mismatch("code_point", 32'(code_point), 32'(want.code));
          if (valid_res !== want.ok)
            report_mismatch("valid_res", 32'(valid_res), 32'(want.ok));
          if (byte_count !== want.count)
            report_mismatch("byte_count", 32'(byte_count), 32'(want.count));
          if (last_of_run !== want.last)
            report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
        end
      end
      in_took     <= took_in;
      items_taken <= items_taken + (took_in ? 1 : 0);
      outstanding <= expected_results.size();
      if (took_in || took_out) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: timeout with %0d results outstanding", expected_results.size());
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.data = b;
    it.eot  = eot;
    pending_bytes.push_back(it);
    items_pushed++;
  endtask

  task automatic drain();
    while (items_taken != items_pushed || outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] lead_for(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    if (len == 1) return {1'b0, r[6:0]};
    return (8'hff << (8 - len)) | (r & (8'h7f >> len));
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  task automatic random_text(input int n);
    int         made;
    int         kind;
    int         len;
    int         conts;
    logic [7:0] r;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(1, MAX_SEQ);
        send(lead_for(len), 1'b0);
        made++;
        for (int i = 1; i < len; i++) begin
          send(cont_byte(), 1'b0);
          made++;
        end
      end else if (kind < 82) begin
        len   = $urandom_range(2, MAX_SEQ);
        conts = $urandom_range(0, len - 2);
        send(lead_for(len), 1'b0);
        made++;
        for (int i = 0; i < conts; i++) begin
          send(cont_byte(), 1'b0);
          made++;
        end
        r = 8'($urandom);
        if ($urandom_range(2) == 0) begin
          send(r, 1'b1);
        end else begin
          if (r[7:6] == 2'b10) r[6] = 1'b1;
          send(r, 1'b0);
        end
        made++;
      end else if (kind < 93) begin
        send(8'($urandom), 1'b0);
        made++;
      end else begin
        send(8'($urandom), 1'b1);
        made++;
      end
    end
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    idle_pct  = sender_pct;
    stall_pct = receiver_pct;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(0, 0);
    send(8'h00, 1'b0);
    send(8'h7f, 1'b0);
    send(8'h80, 1'b0);
    send(8'hbf, 1'b0);
    send(8'hfe, 1'b0);
    send(8'hff, 1'b0);
    send(8'hc0, 1'b0);
    send(8'h80, 1'b0);
    send(8'hf8, 1'b0);
    send(8'h88, 1'b0);
    repeat (3) send(8'h80, 1'b0);
    send(8'hfd, 1'b0);
    repeat (5) send(8'hbf, 1'b0);
    send(8'he2, 1'b0);
    send(8'h82, 1'b0);
    send(8'h41, 1'b0);
    send(8'hf0, 1'b0);
    send(8'h9f, 1'b0);
    send(8'h98, 1'b0);
    send(8'h00, 1'b1);
    send(8'hff, 1'b1);
    drain();

    random_text(60);
    drain();
    set_idling(60, 0);
    random_text(60);
    drain();
    set_idling(0, 60);
    random_text(60);
    drain();
    set_idling(32, 32);
    random_text(60);
    drain();

    // The receiver holds off for a long stretch while bytes keep coming.
    set_idling(0, 0);
    hold_asked++;
    random_text(70);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (outstanding != 0) report_mismatch("results never received", 32'(outstanding), 32'h0);
    $display("tb: %0d bytes decoded over six idling phases including a long output hold-off",
             items_taken);
    $display("tb: %0d results checked, %0d of them error results, %0d mismatches",
             results_checked, error_results, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* utf8_stream_decoder_top.f */
rtl/u8sd_pkg.sv
rtl/u8sd_decode.sv
rtl/utf8_stream_decoder_top.sv
test/testbench.sv
